// ----- hw/rtl/mspnh_pkg.sv -----
package mspnh_pkg;

  localparam int unsigned NodeCountDef    = 32;
  localparam int unsigned EdgesPerNodeDef = 8;
  localparam int unsigned DistInfDef      = 65535;

  localparam int unsigned OpW     = 2;
  localparam int unsigned NodeW   = 5;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned CostW   = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned StatusW = 2;

  localparam logic [OpW-1:0] OpWriteNode = 2'd0;
  localparam logic [OpW-1:0] OpWriteEdge = 2'd1;
  localparam logic [OpW-1:0] OpRoute     = 2'd2;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StUnused = 2'd1;
  localparam logic [StatusW-1:0] StNoPath = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted transaction
    logic do_write;   // apply node/edge write
    logic clr_start;  // begin distance/visited clear sweep
    logic clr_step;
    logic scan_start; // begin min-distance scan
    logic scan_step;
    logic scan_take;  // visit the selected node
    logic edge_start; // begin relaxing edges of current node
    logic edge_rd;    // issue edge memory read
    logic edge_relax; // relax with registered edge data
    logic walk_start; // begin predecessor walk
    logic walk_step;
    logic set_result;
  } mspnh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_route;
    logic pre_bad;    // out-of-range or unused address
    logic pre_same;   // start equals destination
    logic clr_done;
    logic scan_done;
    logic scan_found;
    logic cur_is_dest;
    logic edge_done;
    logic walk_done;
  } mspnh_stat_t;

endpackage

// ----- hw/rtl/mesh_shortest_path_next_hop.sv -----
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_ready_o, operation_i .. destination_i
// out     | output    | out_valid_o, out_ready_i, next_hop_o, status_o
//
// A write is decoded and applied, then answered. A route query that passes
// the address checks repeats a min-distance scan over all nodes, visits the
// selected node and relaxes each of its edges, then walks the predecessors
// back from the destination and clears the search state before answering.
// One transaction at a time; the next is taken once the result is delivered.
// rst_ni clears node flags, edge counts, distances and visit flags at once.
module mesh_shortest_path_next_hop #(
  parameter int unsigned NODE_COUNT     = mspnh_pkg::NodeCountDef,
  parameter int unsigned EDGES_PER_NODE = mspnh_pkg::EdgesPerNodeDef,
  parameter int unsigned DIST_INF       = mspnh_pkg::DistInfDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mspnh_pkg::OpW-1:0]     operation_i,
  input  logic [mspnh_pkg::NodeW-1:0]   node_i,
  input  logic [mspnh_pkg::SlotW-1:0]   slot_i,
  input  logic [mspnh_pkg::NodeW-1:0]   neighbour_i,
  input  logic [mspnh_pkg::CostW-1:0]   cost_i,
  input  logic                          in_use_i,
  input  logic [mspnh_pkg::CountW-1:0]  edge_count_i,
  input  logic [mspnh_pkg::NodeW-1:0]   destination_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mspnh_pkg::NodeW-1:0]   next_hop_o,
  output logic [mspnh_pkg::StatusW-1:0] status_o
);

  mspnh_pkg::mspnh_cmd_t  cmd;
  mspnh_pkg::mspnh_stat_t stat;

  mspnh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  mspnh_dp #(
    .NODE_COUNT(NODE_COUNT), .EDGES_PER_NODE(EDGES_PER_NODE), .DIST_INF(DIST_INF)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .operation_i, .node_i, .slot_i, .neighbour_i, .cost_i, .in_use_i,
    .edge_count_i, .destination_i, .next_hop_o, .status_o
  );

  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");

  a_hop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mspnh_pkg::StOk) |-> next_hop_o == '0)
    else $error("nonzero hop on failure");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("double accept");

endmodule

// ----- hw/rtl/mspnh_ctrl.sv -----
module mspnh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mspnh_pkg::mspnh_stat_t stat_i,
  output mspnh_pkg::mspnh_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StDecode, StScan, StEdgeRd, StEdgeWait, StEdgeRelax,
    StWalk, StClear, StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        cmd_o.set_result = 1'b1;
        if (!stat_i.is_route) begin
          cmd_o.do_write = 1'b1;
          state_d        = StDone;
        end else if (stat_i.pre_bad || stat_i.pre_same) begin
          state_d = StDone;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        if (!stat_i.scan_done) begin
          cmd_o.scan_step = 1'b1;
        end else if (stat_i.scan_found) begin
          cmd_o.scan_take  = 1'b1;
          cmd_o.edge_start = 1'b1;
          state_d          = StEdgeRd;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = StWalk;
        end
      end
      StEdgeRd: begin
        if (stat_i.edge_done) begin
          if (stat_i.cur_is_dest) begin
            cmd_o.walk_start = 1'b1;
            state_d          = StWalk;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = StEdgeWait;
        end
      end
      StEdgeWait: begin
        state_d = StEdgeRelax;
      end
      StEdgeRelax: begin
        cmd_o.edge_relax = 1'b1;
        state_d          = StEdgeRd;
      end
      StWalk: begin
        if (stat_i.walk_done) begin
          cmd_o.clr_start = 1'b1;
          state_d         = StClear;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      StClear: begin
        if (stat_i.clr_done) begin
          state_d = StDone;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      StDone: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/mspnh_dp.sv -----
module mspnh_dp #(
  parameter int unsigned NODE_COUNT     = mspnh_pkg::NodeCountDef,
  parameter int unsigned EDGES_PER_NODE = mspnh_pkg::EdgesPerNodeDef,
  parameter int unsigned DIST_INF       = mspnh_pkg::DistInfDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mspnh_pkg::mspnh_cmd_t               cmd_i,
  output mspnh_pkg::mspnh_stat_t              stat_o,
  input  logic [mspnh_pkg::OpW-1:0]          operation_i,
  input  logic [mspnh_pkg::NodeW-1:0]        node_i,
  input  logic [mspnh_pkg::SlotW-1:0]        slot_i,
  input  logic [mspnh_pkg::NodeW-1:0]        neighbour_i,
  input  logic [mspnh_pkg::CostW-1:0]        cost_i,
  input  logic                               in_use_i,
  input  logic [mspnh_pkg::CountW-1:0]       edge_count_i,
  input  logic [mspnh_pkg::NodeW-1:0]        destination_i,
  output logic [mspnh_pkg::NodeW-1:0]        next_hop_o,
  output logic [mspnh_pkg::StatusW-1:0]      status_o
);

  localparam int unsigned NW = mspnh_pkg::NodeW;
  localparam int unsigned CW = mspnh_pkg::CostW;
  localparam int unsigned IdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned KCW = $clog2(EDGES_PER_NODE + 1);
  localparam int unsigned ScW = $clog2(NODE_COUNT + 1);
  localparam int unsigned EDepth = NODE_COUNT * EDGES_PER_NODE;
  localparam int unsigned EAW = $clog2(EDepth);
  localparam logic [CW:0] Inf = (CW+1)'(DIST_INF);

  // latched transaction
  logic [mspnh_pkg::OpW-1:0]    op_q;
  logic [NW-1:0]                node_q, nb_q, dest_q;
  logic [mspnh_pkg::SlotW-1:0]  slot_q;
  logic [CW-1:0]                cost_q;
  logic                         iu_q;
  logic [mspnh_pkg::CountW-1:0] ec_q;

  // graph state
  logic [NODE_COUNT-1:0] used_q;
  logic [KCW-1:0]        cnt_q [NODE_COUNT];
  logic [NW-1:0]         etgt_mem [EDepth];
  logic [CW-1:0]         ecost_mem [EDepth];
  logic [NW-1:0]         etgt_rd_q;
  logic [CW-1:0]         ecost_rd_q;

  // search state; dist memory, visited flags, predecessor memory
  logic [CW-1:0]         dist_q [NODE_COUNT];
  logic [NODE_COUNT-1:0] vis_q;
  logic [IdxW-1:0]       pred_q [NODE_COUNT];

  logic [ScW-1:0]  sc_q;
  logic [IdxW-1:0] best_q, cur_q, walk_q;
  logic [CW-1:0]   bestd_q, curd_q;
  logic            found_q;
  logic [KCW-1:0]  k_q;
  logic [ScW-1:0]  wn_q;
  logic            walk_done_q;
  logic [NW-1:0]   hop_q;
  logic [mspnh_pkg::StatusW-1:0] st_q;

  logic node_ok, dest_ok, nodew_ok, edgew_ok;
  assign node_ok  = 32'(node_q) < NODE_COUNT;
  assign dest_ok  = 32'(dest_q) < NODE_COUNT;
  assign nodew_ok = node_ok;
  assign edgew_ok = node_ok && (32'(slot_q) < EDGES_PER_NODE);

  logic [IdxW-1:0] s_idx, d_idx, sc_idx, nb_idx;
  assign s_idx  = IdxW'(node_q);
  assign d_idx  = IdxW'(dest_q);
  assign sc_idx = sc_q[IdxW-1:0];
  assign nb_idx = IdxW'(etgt_rd_q);

  logic [EAW-1:0] wr_addr, rd_addr;
  assign wr_addr = EAW'(32'(node_q) * EDGES_PER_NODE + 32'(slot_q));
  assign rd_addr = EAW'(32'(cur_q) * EDGES_PER_NODE + 32'(k_q));

  logic [CW:0] sum;
  assign sum = {1'b0, curd_q} + {1'b0, ecost_rd_q};

  logic nb_in, relax_ok;
  assign nb_in    = 32'(etgt_rd_q) < NODE_COUNT;
  assign relax_ok = nb_in && !vis_q[nb_idx] && (sum < Inf) &&
                    (sum < {1'b0, dist_q[nb_idx]});

  logic cand;
  assign cand = used_q[sc_idx] && !vis_q[sc_idx] && (dist_q[sc_idx] <= bestd_q);

  logic [IdxW-1:0] p_walk;
  assign p_walk = pred_q[walk_q];

  assign stat_o.is_route    = (op_q == mspnh_pkg::OpRoute);
  assign stat_o.pre_bad     = !node_ok || !dest_ok || !used_q[s_idx] || !used_q[d_idx];
  assign stat_o.pre_same    = (node_q == dest_q);
  assign stat_o.clr_done    = (sc_q == ScW'(NODE_COUNT));
  assign stat_o.scan_done   = (sc_q == ScW'(NODE_COUNT));
  assign stat_o.scan_found  = found_q;
  assign stat_o.cur_is_dest = (cur_q == d_idx);
  assign stat_o.edge_done   = (k_q == cnt_q[cur_q]);
  assign stat_o.walk_done   = walk_done_q;

  assign next_hop_o = hop_q;
  assign status_o   = st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      node_q <= node_i;
      slot_q <= slot_i;
      nb_q   <= neighbour_i;
      cost_q <= cost_i;
      iu_q   <= in_use_i;
      ec_q   <= edge_count_i;
      dest_q <= destination_i;
    end
    if (cmd_i.do_write && op_q == mspnh_pkg::OpWriteEdge && edgew_ok) begin
      etgt_mem[wr_addr]  <= nb_q;
      ecost_mem[wr_addr] <= cost_q;
    end
    if (cmd_i.edge_rd) begin
      etgt_rd_q  <= etgt_mem[rd_addr];
      ecost_rd_q <= ecost_mem[rd_addr];
    end
    if (cmd_i.edge_relax && relax_ok) begin
      pred_q[nb_idx] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      vis_q       <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        cnt_q[i]  <= '0;
        dist_q[i] <= CW'(DIST_INF);
      end
      sc_q        <= '0;
      best_q      <= '0;
      bestd_q     <= '0;
      found_q     <= 1'b0;
      cur_q       <= '0;
      curd_q      <= '0;
      k_q         <= '0;
      walk_q      <= '0;
      wn_q        <= '0;
      walk_done_q <= 1'b0;
      hop_q       <= '0;
      st_q        <= mspnh_pkg::StOk;
    end else begin
      if (cmd_i.do_write && op_q == mspnh_pkg::OpWriteNode && nodew_ok) begin
        used_q[s_idx] <= iu_q;
        cnt_q[s_idx]  <= (32'(ec_q) > EDGES_PER_NODE) ? KCW'(EDGES_PER_NODE) : KCW'(ec_q);
      end
      if (cmd_i.set_result) begin
        hop_q <= '0;
        if (op_q != mspnh_pkg::OpRoute) begin
          st_q <= mspnh_pkg::StOk;
        end else if (stat_o.pre_bad) begin
          st_q <= mspnh_pkg::StUnused;
        end else begin
          st_q <= mspnh_pkg::StNoPath;
        end
      end
      if (cmd_i.scan_start) begin
        sc_q    <= '0;
        bestd_q <= CW'(DIST_INF);
        found_q <= 1'b0;
        // first scan of the query seeds the start distance
        if (vis_q == '0) begin
          dist_q[s_idx] <= '0;
        end
      end
      if (cmd_i.scan_step) begin
        if (cand) begin
          best_q  <= sc_idx;
          bestd_q <= dist_q[sc_idx];
          found_q <= 1'b1;
        end
        sc_q <= sc_q + 1'b1;
      end
      if (cmd_i.scan_take) begin
        cur_q  <= best_q;
        curd_q <= dist_q[best_q];
        vis_q[best_q] <= 1'b1;
      end
      if (cmd_i.edge_start) begin
        k_q <= '0;
      end
      if (cmd_i.edge_rd) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.edge_relax && relax_ok) begin
        dist_q[nb_idx] <= sum[CW-1:0];
      end
      if (cmd_i.walk_start) begin
        walk_q      <= d_idx;
        wn_q        <= '0;
        walk_done_q <= !(dist_q[d_idx] < CW'(DIST_INF));
      end
      if (cmd_i.walk_step) begin
        if (p_walk == s_idx) begin
          hop_q       <= NW'(walk_q);
          st_q        <= mspnh_pkg::StOk;
          walk_done_q <= 1'b1;
        end else begin
          walk_q <= p_walk;
          wn_q   <= wn_q + 1'b1;
          if (wn_q == ScW'(NODE_COUNT - 1)) begin
            walk_done_q <= 1'b1;
          end
        end
      end
      if (cmd_i.clr_start) begin
        sc_q <= '0;
      end
      if (cmd_i.clr_step) begin
        dist_q[sc_idx] <= CW'(DIST_INF);
        vis_q[sc_idx]  <= 1'b0;
        sc_q           <= sc_q + 1'b1;
      end
    end
  end

endmodule

// ----- verif/mspnh_checker.sv -----
module mspnh_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mspnh_pkg::OpW-1:0]     operation_i,
  input  logic [mspnh_pkg::NodeW-1:0]   node_i,
  input  logic [mspnh_pkg::SlotW-1:0]   slot_i,
  input  logic [mspnh_pkg::NodeW-1:0]   neighbour_i,
  input  logic [mspnh_pkg::CostW-1:0]   cost_i,
  input  logic                          in_use_i,
  input  logic [mspnh_pkg::CountW-1:0]  edge_count_i,
  input  logic [mspnh_pkg::NodeW-1:0]   destination_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mspnh_pkg::NodeW-1:0]   next_hop_i,
  input  logic [mspnh_pkg::StatusW-1:0] status_i,
  output int                            fail_count,
  output int                            pending,
  output int                            routes_ok,
  output int                            routes_failed
);

  localparam int Nodes = mspnh_pkg::NodeCountDef;
  localparam int Edges = mspnh_pkg::EdgesPerNodeDef;
  localparam int Inf   = mspnh_pkg::DistInfDef;

  typedef struct packed {
    logic [mspnh_pkg::NodeW-1:0]   hop;
    logic [mspnh_pkg::StatusW-1:0] status;
  } hop_result_t;

  logic                         node_used_m [Nodes];
  logic [mspnh_pkg::CountW-1:0] node_cnt_m  [Nodes];
  logic [mspnh_pkg::NodeW-1:0]  edge_tgt_m  [Nodes*Edges];
  logic [mspnh_pkg::CostW-1:0]  edge_cost_m [Nodes*Edges];
  logic [mspnh_pkg::NodeW-1:0]  pred_m      [Nodes];
  hop_result_t                  hop_q[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic hop_result_t plan_route(input int s, input int d);
    int          tdist [Nodes];
    bit          seen [Nodes];
    int          u, best_d, v, sum, h, p;
    hop_result_t r;
    r = '{hop: '0, status: mspnh_pkg::StOk};
    if (!node_used_m[s] || !node_used_m[d]) begin
      r.status = mspnh_pkg::StUnused;
      return r;
    end
    if (s == d) begin
      r.status = mspnh_pkg::StNoPath;
      return r;
    end
    foreach (tdist[i]) begin
      tdist[i] = Inf;
      seen[i] = 1'b0;
    end
    tdist[s] = 0;
    forever begin
      u = -1;
      best_d = Inf;
      // ties go to the highest index
      for (int i = 0; i < Nodes; i++)
        if (node_used_m[i] && !seen[i] && tdist[i] <= best_d) begin
          best_d = tdist[i];
          u = i;
        end
      if (u < 0) break;
      for (int k = 0; k < node_cnt_m[u] && k < Edges; k++) begin
        v = edge_tgt_m[u*Edges+k];
        if (v >= Nodes || seen[v]) continue;
        sum = tdist[u] + int'(edge_cost_m[u*Edges+k]);
        if (sum < Inf && sum < tdist[v]) begin
          tdist[v] = sum;
          pred_m[v] = mspnh_pkg::NodeW'(u);
        end
      end
      seen[u] = 1'b1;
      if (u == d) break;
    end
    r.status = mspnh_pkg::StNoPath;
    if (tdist[d] < Inf) begin
      h = d;
      for (int n = 0; n < Nodes; n++) begin
        p = pred_m[h];
        if (p == s) begin
          r.hop = mspnh_pkg::NodeW'(h);
          r.status = mspnh_pkg::StOk;
          break;
        end
        h = p;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hop_result_t want;
    if (!rst_ni) begin
      foreach (node_used_m[i]) begin
        node_used_m[i] = 1'b0;
        node_cnt_m[i]  = '0;
        pred_m[i]      = '0;
      end
      hop_q.delete();
      fail_count = 0;
      pending = 0;
      routes_ok = 0;
      routes_failed = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        want = '{hop: '0, status: mspnh_pkg::StOk};
        case (operation_i)
          mspnh_pkg::OpWriteNode: begin
            node_used_m[node_i] = in_use_i;
            node_cnt_m[node_i]  = (edge_count_i > Edges) ?
                                  mspnh_pkg::CountW'(Edges) : edge_count_i;
          end
          mspnh_pkg::OpWriteEdge: begin
            edge_tgt_m[node_i*Edges+slot_i]  = neighbour_i;
            edge_cost_m[node_i*Edges+slot_i] = cost_i;
          end
          mspnh_pkg::OpRoute: begin
            want = plan_route(node_i, destination_i);
            if (want.status == mspnh_pkg::StOk) routes_ok++;
            else routes_failed++;
          end
          default: ;
        endcase
        hop_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (hop_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = hop_q.pop_front();
          if (next_hop_i !== want.hop)
            report_mismatch($sformatf("next_hop %0d, want %0d", next_hop_i, want.hop));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
        end
      end
      pending = hop_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

  localparam logic [mspnh_pkg::OpW-1:0] OpSpare = 2'd3;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [mspnh_pkg::OpW-1:0]     operation_i = '0;
  logic [mspnh_pkg::NodeW-1:0]   node_i = '0;
  logic [mspnh_pkg::SlotW-1:0]   slot_i = '0;
  logic [mspnh_pkg::NodeW-1:0]   neighbour_i = '0;
  logic [mspnh_pkg::CostW-1:0]   cost_i = '0;
  logic                          in_use_i = 1'b0;
  logic [mspnh_pkg::CountW-1:0]  edge_count_i = '0;
  logic [mspnh_pkg::NodeW-1:0]   destination_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [mspnh_pkg::NodeW-1:0]   next_hop_o;
  logic [mspnh_pkg::StatusW-1:0] status_o;

  int fail_count, pending, routes_ok, routes_failed;
  int snd_idle = 0;
  int rcv_stall = 0;
  int items_sent = 0;
  bit used_sh [32];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  mesh_shortest_path_next_hop u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .node_i, .slot_i,
    .neighbour_i, .cost_i, .in_use_i, .edge_count_i, .destination_i,
    .out_valid_o, .out_ready_i, .next_hop_o, .status_o
  );

  mspnh_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .node_i,
    .slot_i, .neighbour_i, .cost_i, .in_use_i, .edge_count_i, .destination_i,
    .out_valid_i(out_valid_o), .out_ready_i, .next_hop_i(next_hop_o),
    .status_i(status_o), .fail_count, .pending, .routes_ok, .routes_failed
  );

  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(0, 99) >= rcv_stall);

  // one transaction; valid stays high into the next one unless we idle
  task automatic send(input logic [mspnh_pkg::OpW-1:0] op, input int nd, input int sl,
                      input int nb, input int cs, input int iu, input int ec,
                      input int ds);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    operation_i   <= op;
    node_i        <= mspnh_pkg::NodeW'(nd);
    slot_i        <= mspnh_pkg::SlotW'(sl);
    neighbour_i   <= mspnh_pkg::NodeW'(nb);
    cost_i        <= mspnh_pkg::CostW'(cs);
    in_use_i      <= 1'(iu);
    edge_count_i  <= mspnh_pkg::CountW'(ec);
    destination_i <= mspnh_pkg::NodeW'(ds);
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == mspnh_pkg::OpWriteNode) used_sh[nd] = 1'(iu);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic int rand_cost();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      3:       return $urandom_range(30000, 65534);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int pick_used();
    int n;
    for (int t = 0; t < 20; t++) begin
      n = $urandom_range(0, 31);
      if (used_sh[n]) return n;
    end
    return n;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      send(mspnh_pkg::OpRoute, pick_used(), $urandom_range(0, 7), $urandom_range(0, 31),
           $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 15),
           pick_used());
    else if (r < 62)
      send(mspnh_pkg::OpRoute, $urandom_range(0, 31), $urandom_range(0, 7),
           $urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 1),
           $urandom_range(0, 15), $urandom_range(0, 31));
    else if (r < 80)
      send(mspnh_pkg::OpWriteEdge, $urandom_range(0, 31), $urandom_range(0, 7),
           $urandom_range(0, 31), rand_cost(), $urandom_range(0, 1),
           $urandom_range(0, 15), $urandom_range(0, 31));
    else if (r < 96)
      send(mspnh_pkg::OpWriteNode, $urandom_range(0, 31), $urandom_range(0, 7),
           $urandom_range(0, 31), $urandom_range(0, 65535), ($urandom_range(0, 99) < 80),
           $urandom_range(0, 15), $urandom_range(0, 31));
    else
      send(OpSpare, $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 31),
           $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 15),
           $urandom_range(0, 31));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every edge slot gets content first so no query reads an unwritten slot
    for (int n = 0; n < 32; n++)
      for (int s = 0; s < 8; s++)
        send(mspnh_pkg::OpWriteEdge, n, s, $urandom_range(0, 31), rand_cost(), 0, 0, 0);
    for (int n = 0; n < 32; n++)
      send(mspnh_pkg::OpWriteNode, n, 0, 0, 0, ($urandom_range(0, 99) < 75),
           $urandom_range(0, 15), 0);

    // directed corners
    send(mspnh_pkg::OpWriteNode, 0, 0, 0, 0, 1, 15, 0);    // saturating edge count
    send(mspnh_pkg::OpWriteEdge, 0, 0, 1, 0, 0, 0, 0);
    send(mspnh_pkg::OpWriteEdge, 0, 1, 2, 65535, 0, 0, 0);
    send(mspnh_pkg::OpWriteNode, 1, 7, 31, 65535, 1, 1, 31);
    send(mspnh_pkg::OpWriteEdge, 1, 0, 2, 65534, 0, 0, 0); // sum lands just below infinity
    send(mspnh_pkg::OpWriteNode, 2, 0, 0, 0, 1, 0, 0);
    send(mspnh_pkg::OpWriteNode, 31, 0, 0, 0, 1, 0, 0);    // no outgoing edges
    send(mspnh_pkg::OpWriteNode, 30, 0, 0, 0, 0, 8, 0);
    send(mspnh_pkg::OpRoute, 0, 0, 0, 0, 0, 0, 2);
    send(mspnh_pkg::OpRoute, 0, 0, 0, 0, 0, 0, 1);
    send(mspnh_pkg::OpRoute, 1, 0, 0, 0, 0, 0, 2);
    send(mspnh_pkg::OpRoute, 31, 0, 0, 0, 0, 0, 0);
    send(mspnh_pkg::OpRoute, 0, 0, 0, 0, 0, 0, 31);
    send(mspnh_pkg::OpRoute, 0, 0, 0, 0, 0, 0, 0);         // start equals destination
    send(mspnh_pkg::OpRoute, 0, 0, 0, 0, 0, 0, 30);        // destination unused
    send(mspnh_pkg::OpRoute, 30, 0, 0, 0, 0, 0, 0);        // start unused
    send(OpSpare, 31, 7, 31, 65535, 1, 15, 31);
    send(mspnh_pkg::OpWriteNode, 31, 7, 31, 65535, 1, 15, 31);
    send(mspnh_pkg::OpRoute, 31, 7, 31, 65535, 1, 15, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      snd_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 49 : 32) : 0;
      rcv_stall = (ph == 2) ? 49 : (ph == 3) ? 32 : 0;
      repeat (50) random_item();
      drain();
    end
    snd_idle  = 0;
    rcv_stall = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d transactions: graph writes, spare opcodes and route queries.",
             items_sent);
    $display("Routes found: %0d, unused-address or no-path answers: %0d.",
             routes_ok, routes_failed);
    if (fail_count == 0) begin
      $display("mesh_shortest_path_next_hop verification clean");
    end else begin
      $display("mesh_shortest_path_next_hop verification failed");
    end
    $finish;
  end

  initial begin
    #(8 * 8_000_000);
    $display("mesh_shortest_path_next_hop verification failed");
    $finish;
  end

endmodule
